### hdl/dts_pkg.sv
// Package with constants and types shared by the topological sort block.
package dts_pkg;
    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;
    localparam int NodeW = $clog2(MaxNodes);
    localparam int EdgeW = $clog2(MaxEdges);
    localparam int PtrW = EdgeW + 1;
    localparam int CntW = NodeW + 1;
    localparam logic [PtrW-1:0] NilEntry = PtrW'(MaxEdges);

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;
endpackage

### hdl/dfs_topological_sort.sv
// Top level of the depth-first topological sort block.
//
// Input channel s_axis: one transfer is an add-edge item (mode 0) or a run
// item (mode 1). An add item stores src->dst (and dst->src when undirected)
// in per-node neighbor lists held in block memories; it yields one status
// transfer on m_axis. A run item clears the visited marks, walks
// depth-first from roots 0..root_count-1 with a stack in memory, then emits
// the nodes in reverse finish order, tlast on the final one. A run that
// finishes nothing emits one empty-order transfer.
// Memory reads are registered and the memories are single-ported. Items
// are taken one at a time; s_axis_tready is low while an item is at work
// or a result waits.
// Reset (aresetn low, synchronous) empties the edge store: list heads are
// kept as valid bits so no memory sweep is needed. When m_axis_tready is low
// the result holds in the output register and the sequencer waits.
module dfs_topological_sort
    import dts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: mode[0], src_node[6:1], dst_node[12:7], directed[13], root_count[20:14]
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: kind[1:0], node[7:2], edge_rejected[8]
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    typedef enum logic [4:0] {
        S_IDLE, S_ADD1, S_ADD2, S_ADD3, S_CLR, S_ROOT, S_ROOT_RD, S_PUSH,
        S_TOP_RD, S_TOP, S_EDGE, S_NB, S_EMIT_RD, S_EMIT
    } state_t;

    state_t state_reg;

    // Memories.
    logic [NodeW-1:0] tgt_mem [MaxEdges];
    logic [PtrW-1:0]  link_mem [MaxEdges];
    logic [PtrW-1:0]  head_mem [MaxNodes];
    logic [EdgeW-1:0] tail_mem [MaxNodes];
    logic [NodeW-1:0] stk_node_mem [MaxNodes];
    logic [PtrW-1:0]  stk_cur_mem [MaxNodes];
    logic [NodeW-1:0] fin_mem [MaxNodes];
    logic [MaxNodes-1:0] head_valid_reg;
    logic [MaxNodes-1:0] visited_reg;

    logic [PtrW-1:0]  used_reg;
    logic [CntW-1:0]  fin_cnt_reg;
    logic [CntW-1:0]  sp_reg;
    logic [CntW-1:0]  root_reg;
    logic [CntW-1:0]  roots_reg;
    logic [NodeW-1:0] u_reg, v_reg, nb_reg;
    logic             dir_reg, second_reg, link_pend_reg;
    logic [PtrW-1:0]  head_rd_reg;
    logic [EdgeW-1:0] tail_rd_reg;
    logic [NodeW-1:0] tgt_rd_reg, stk_node_rd_reg, fin_rd_reg;
    logic [PtrW-1:0]  link_rd_reg, stk_cur_rd_reg;

    logic [1:0]       o_kind_reg;
    logic [NodeW-1:0] o_node_reg;
    logic             o_rej_reg, o_last_reg, o_valid_reg;

    // Input fields.
    logic             in_mode, in_dir;
    logic [NodeW-1:0] in_src, in_dst;
    logic [6:0]       in_roots;
    assign in_mode  = s_axis_tdata[0];
    assign in_src   = s_axis_tdata[6:1];
    assign in_dst   = s_axis_tdata[12:7];
    assign in_dir   = s_axis_tdata[13];
    assign in_roots = s_axis_tdata[20:14];

    assign s_axis_tready = (state_reg == S_IDLE) && !o_valid_reg;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {7'd0, o_rej_reg, o_node_reg, o_kind_reg};
    assign m_axis_tlast  = o_last_reg;

    logic [NodeW-1:0] from_node, to_node;
    assign from_node = second_reg ? v_reg : u_reg;
    assign to_node   = second_reg ? u_reg : v_reg;
    logic [NodeW-1:0] top_idx;
    assign top_idx = NodeW'(sp_reg - CntW'(1));

    // Single sequencer with registered memory reads.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            head_valid_reg <= '0;
            visited_reg    <= '0;
            used_reg       <= '0;
            fin_cnt_reg    <= '0;
            o_valid_reg    <= 1'b0;
        end else begin
            if (o_valid_reg && m_axis_tready) o_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        u_reg      <= in_src;
                        v_reg      <= in_dst;
                        dir_reg    <= in_dir;
                        second_reg <= 1'b0;
                        roots_reg  <= (in_roots > 7'(MaxNodes)) ? CntW'(MaxNodes)
                                                               : CntW'(in_roots);
                        root_reg   <= '0;
                        sp_reg     <= '0;
                        if (!in_mode) begin
                            if (used_reg + PtrW'(in_dir ? 1 : 2) > PtrW'(MaxEdges)) begin
                                o_kind_reg  <= KIND_STATUS;
                                o_node_reg  <= '0;
                                o_rej_reg   <= 1'b1;
                                o_last_reg  <= 1'b1;
                                o_valid_reg <= 1'b1;
                            end else begin
                                state_reg <= S_ADD1;
                            end
                        end else begin
                            visited_reg <= '0;
                            fin_cnt_reg <= '0;
                            state_reg   <= S_CLR;
                        end
                    end
                end
                // Append one entry: read the tail, write the entry, then link the old tail.
                S_ADD1: begin
                    tail_rd_reg <= tail_mem[from_node];
                    state_reg   <= S_ADD2;
                end
                S_ADD2: begin
                    tgt_mem[used_reg[EdgeW-1:0]]  <= to_node;
                    link_mem[used_reg[EdgeW-1:0]] <= NilEntry;
                    link_pend_reg <= head_valid_reg[from_node];
                    if (!head_valid_reg[from_node]) begin
                        head_mem[from_node] <= used_reg;
                        head_valid_reg[from_node] <= 1'b1;
                    end
                    tail_mem[from_node] <= used_reg[EdgeW-1:0];
                    used_reg  <= used_reg + PtrW'(1);
                    state_reg <= S_ADD3;
                end
                S_ADD3: begin
                    if (link_pend_reg) begin
                        link_mem[tail_rd_reg] <= used_reg - PtrW'(1);
                    end
                    if (!dir_reg && !second_reg) begin
                        second_reg <= 1'b1;
                        state_reg  <= S_ADD1;
                    end else begin
                        o_kind_reg  <= KIND_STATUS;
                        o_node_reg  <= '0;
                        o_rej_reg   <= 1'b0;
                        o_last_reg  <= 1'b1;
                        o_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                // Clearing pass timing for visited marks.
                S_CLR: begin
                    root_reg <= root_reg + CntW'(1);
                    if (root_reg == CntW'(MaxNodes - 1)) begin
                        root_reg  <= '0;
                        state_reg <= S_ROOT;
                    end
                end
                // Pick next unvisited root.
                S_ROOT: begin
                    if (root_reg >= roots_reg) begin
                        root_reg  <= '0;
                        state_reg <= S_EMIT_RD;
                    end else if (visited_reg[NodeW'(root_reg)]) begin
                        root_reg <= root_reg + CntW'(1);
                    end else begin
                        nb_reg    <= NodeW'(root_reg);
                        root_reg  <= root_reg + CntW'(1);
                        state_reg <= S_ROOT_RD;
                    end
                end
                S_ROOT_RD: begin
                    head_rd_reg <= head_mem[nb_reg];
                    state_reg   <= S_PUSH;
                end
                S_PUSH: begin
                    visited_reg[nb_reg]   <= 1'b1;
                    stk_node_mem[NodeW'(sp_reg)] <= nb_reg;
                    stk_cur_mem[NodeW'(sp_reg)]  <= head_valid_reg[nb_reg] ? head_rd_reg
                                                                         : NilEntry;
                    sp_reg    <= sp_reg + CntW'(1);
                    state_reg <= S_TOP_RD;
                end
                S_TOP_RD: begin
                    if (sp_reg == '0) begin
                        state_reg <= S_ROOT;
                    end else begin
                        stk_node_rd_reg <= stk_node_mem[top_idx];
                        stk_cur_rd_reg  <= stk_cur_mem[top_idx];
                        state_reg       <= S_TOP;
                    end
                end
                S_TOP: begin
                    if (stk_cur_rd_reg >= NilEntry) begin
                        fin_mem[NodeW'(fin_cnt_reg)] <= stk_node_rd_reg;
                        fin_cnt_reg <= fin_cnt_reg + CntW'(1);
                        sp_reg      <= sp_reg - CntW'(1);
                        state_reg   <= S_TOP_RD;
                    end else begin
                        tgt_rd_reg   <= tgt_mem[stk_cur_rd_reg[EdgeW-1:0]];
                        link_rd_reg  <= link_mem[stk_cur_rd_reg[EdgeW-1:0]];
                        state_reg    <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    stk_cur_mem[top_idx] <= link_rd_reg;
                    nb_reg      <= tgt_rd_reg;
                    head_rd_reg <= head_mem[tgt_rd_reg];
                    state_reg   <= visited_reg[tgt_rd_reg] ? S_TOP_RD : S_NB;
                end
                S_NB: begin
                    visited_reg[nb_reg] <= 1'b1;
                    stk_node_mem[NodeW'(sp_reg)] <= nb_reg;
                    stk_cur_mem[NodeW'(sp_reg)]  <= head_valid_reg[nb_reg] ? head_rd_reg
                                                                         : NilEntry;
                    sp_reg    <= sp_reg + CntW'(1);
                    state_reg <= S_TOP_RD;
                end
                // Emit in reverse finish order.
                S_EMIT_RD: begin
                    if (fin_cnt_reg == '0) begin
                        o_kind_reg  <= KIND_EMPTY;
                        o_node_reg  <= '0;
                        o_rej_reg   <= 1'b0;
                        o_last_reg  <= 1'b1;
                        o_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end else begin
                        fin_rd_reg <= fin_mem[NodeW'(fin_cnt_reg - CntW'(1))];
                        state_reg  <= S_EMIT;
                    end
                end
                // The next entry loads once the previous transfer has left the register.
                S_EMIT: begin
                    if (!o_valid_reg) begin
                        o_kind_reg  <= KIND_ENTRY;
                        o_node_reg  <= fin_rd_reg;
                        o_rej_reg   <= 1'b0;
                        o_last_reg  <= (fin_cnt_reg == CntW'(1));
                        o_valid_reg <= 1'b1;
                        fin_cnt_reg <= fin_cnt_reg - CntW'(1);
                        state_reg   <= (fin_cnt_reg == CntW'(1)) ? S_IDLE : S_EMIT_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/dts_checker.sv
// Port-level checker for the topological sort block, with its bind.
module dts_checker
    import dts_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // Status and empty results always close their item.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != KIND_ENTRY |-> m_axis_tlast)
        else $error("single result without tlast");
    // Only the defined kinds are produced.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[1:0] == KIND_STATUS ||
                          m_axis_tdata[1:0] == KIND_ENTRY ||
                          m_axis_tdata[1:0] == KIND_EMPTY)
        else $error("bad kind");
    // No new item is taken while a result waits.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
endmodule

bind dfs_topological_sort dts_checker u_dts_checker (.*);

### bench/tb_top.sv
// Self-checking testbench for the depth-first topological sort block.
`timescale 1ns / 1ps

module tb_top
    import dts_pkg::*;
();

    typedef struct packed {
        kind_t      kind;
        logic [5:0] node;
        logic       rejected;
        logic       last;
    } order_result_t;

    // Tracks the edge store and the walk, and holds the results still owed.
    class order_scoreboard_t;
        int unsigned   entry_target[MaxEdges];
        int unsigned   entry_next[MaxEdges];
        int unsigned   head[MaxNodes];
        int unsigned   tail[MaxNodes];
        int unsigned   stored;
        order_result_t owed[$];
        int            failures;

        function new();
            for (int i = 0; i < MaxNodes; i++) head[i] = MaxEdges;
            stored = 0;
            failures = 0;
        endfunction

        function void append(int unsigned from, int unsigned to);
            entry_target[stored] = to;
            entry_next[stored] = MaxEdges;
            if (head[from] == MaxEdges) head[from] = stored;
            else entry_next[tail[from]] = stored;
            tail[from] = stored;
            stored++;
        endfunction

        function void owe(kind_t k, int unsigned n, bit rej, bit lst);
            order_result_t r;
            r.kind = k;
            r.node = n[5:0];
            r.rejected = rej;
            r.last = lst;
            owed = {owed, r};
        endfunction

        // Note one accepted transfer and work out the results it causes.
        function void note_item(bit mode, int unsigned src, int unsigned dst, bit directed,
                                int unsigned roots);
            bit          seen[MaxNodes];
            int unsigned stack_node[MaxNodes];
            int unsigned stack_cur[MaxNodes];
            int unsigned finished[$];
            int unsigned sp;
            int unsigned cur;
            int unsigned nb;
            int unsigned need;
            bit          fits;
            if (mode == 1'b0) begin
                need = directed ? 1 : 2;
                fits = need <= MaxEdges - stored;
                if (fits) begin
                    append(src, dst);
                    if (!directed) append(dst, src);
                end
                owe(KIND_STATUS, 0, !fits, 1'b1);
                return;
            end
            if (roots > MaxNodes) roots = MaxNodes;
            for (int i = 0; i < MaxNodes; i++) seen[i] = 1'b0;
            for (int r = 0; r < roots; r++) begin
                if (seen[r]) continue;
                // Iterative walk: the cursor of each frame points at its next entry.
                seen[r] = 1'b1;
                stack_node[0] = r;
                stack_cur[0] = head[r];
                sp = 1;
                while (sp > 0) begin
                    cur = stack_cur[sp-1];
                    if (cur >= MaxEdges) begin
                        finished = {finished, stack_node[sp-1]};
                        sp--;
                    end else begin
                        nb = entry_target[cur];
                        stack_cur[sp-1] = entry_next[cur];
                        if (!seen[nb] && sp < MaxNodes) begin
                            seen[nb] = 1'b1;
                            stack_node[sp] = nb;
                            stack_cur[sp] = head[nb];
                            sp++;
                        end
                    end
                end
            end
            if (finished.size() == 0) begin
                owe(KIND_EMPTY, 0, 1'b0, 1'b1);
                return;
            end
            for (int i = finished.size() - 1; i >= 0; i--)
                owe(KIND_ENTRY, finished[i], 1'b0, i == 0);
        endfunction

        // Compare one result transfer with the oldest owed result.
        function void check_result(logic [15:0] data, logic lst);
            order_result_t e;
            if (owed.size() == 0) begin
                $error("unexpected result transfer: tdata %h tlast %b", data, lst);
                failures++;
                return;
            end
            e = owed.pop_front();
            if (data[1:0] !== e.kind) begin
                $error("kind: expected %0d, actual %0d", e.kind, data[1:0]);
                failures++;
            end
            if (data[7:2] !== e.node) begin
                $error("node: expected %0d, actual %0d", e.node, data[7:2]);
                failures++;
            end
            if (data[8] !== e.rejected) begin
                $error("edge_rejected: expected %b, actual %b", e.rejected, data[8]);
                failures++;
            end
            if (lst !== e.last) begin
                $error("last: expected %b, actual %b", e.last, lst);
                failures++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: mode, src_node, dst_node, directed, root_count from the lowest bit up.
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: kind, node, edge_rejected from the lowest bit up.
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    order_scoreboard_t sb;
    int              idle_phase;
    int              hold_left;
    bit              pressure_done;

    dfs_topological_sort dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Offer one item, with random gaps before it, and note it once transferred.
    task automatic send_item(bit mode, int unsigned src, int unsigned dst, bit directed,
                             int unsigned roots);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 20 : (idle_phase == 1) ? 81 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, roots[6:0], directed, dst[5:0], src[5:0], mode};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(mode, src, dst, directed, roots);
    endtask

    task automatic add_edge(int unsigned src, int unsigned dst, bit directed);
        send_item(1'b0, src, dst, directed, $urandom_range(127));
    endtask

    task automatic run_sort(int unsigned roots);
        send_item(1'b1, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)), roots);
    endtask

    // Receiver: random stalls in the first two phases, and one long hold-off in the last phase.
    initial begin
        m_axis_tready = 1'b0;
        hold_left = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_phase == 2 && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left = 400;
                m_axis_tready <= 1'b0;
            end else begin
                case (idle_phase)
                    0: m_axis_tready <= $urandom_range(99) >= 81;
                    1: m_axis_tready <= $urandom_range(99) >= 20;
                    default: m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Stimulus and end of test.
    initial begin
        sb = new();
        idle_phase = 0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty runs, every node alone, self loop, cycle, clamp.
        run_sort(0);
        run_sort(64);
        add_edge(0, 1, 1'b1);
        add_edge(1, 2, 1'b0);
        add_edge(5, 5, 1'b0);
        add_edge(63, 0, 1'b1);
        add_edge(2, 0, 1'b1);
        add_edge(63, 63, 1'b1);
        add_edge(0, 63, 1'b0);
        run_sort(127);
        run_sort(3);
        run_sort(1);
        run_sort(0);
        run_sort(65);

        // Random part: mostly edge additions with occasional random sorts; the store fills late.
        for (int i = 0; i < 250; i++) begin
            idle_phase = (i < 85) ? 0 : (i < 170) ? 1 : 2;
            if ($urandom_range(5) == 0) begin
                if ($urandom_range(7) == 0) run_sort($urandom_range(127));
                else run_sort($urandom_range(64));
            end else begin
                add_edge($urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
        if (sb.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit.
    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

### filelist.f
hdl/dts_pkg.sv
hdl/dfs_topological_sort.sv
hdl/dts_checker.sv
bench/tb_top.sv
